// File: src/bps_pkg.sv
// Shared types and constants of the Blinn-Phong fragment shading unit.
package bps_pkg;

   localparam int MUL_W   = 34;          // signed operand width of the shared multiplier
   localparam int PROD_W  = 2 * MUL_W;   // product width
   localparam int SQ_W    = 64;          // radicand width of the square root unit
   localparam int ROOT_W  = 32;          // root width
   localparam int DIV_W   = 46;          // dividend and remainder width of the divider
   localparam int QUO_W   = 15;          // quotient width, unit components reach 16384
   localparam int VERT_COUNT = 3;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_SHADE = 1'b1;

   typedef enum logic [2:0] {
      REG_LIGHT_X = 3'd0,
      REG_LIGHT_Y = 3'd1,
      REG_LIGHT_Z = 3'd2,
      REG_EYE_X   = 3'd3,
      REG_EYE_Y   = 3'd4,
      REG_EYE_Z   = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic               mode;
      logic        [1:0]  vertex_slot;
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic        [16:0] weight_first;
      logic        [16:0] weight_second;
      logic        [16:0] weight_third;
      logic        [23:0] texel_rgb;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       clipped;
   } rsp_payload_type;

endpackage

// File: src/bps_mul.sv
// Shared signed multiplier with a registered product.
module bps_mul (
   input  logic                               clock,
   input  logic signed [bps_pkg::MUL_W-1:0]  a,
   input  logic signed [bps_pkg::MUL_W-1:0]  b,
   output logic signed [bps_pkg::PROD_W-1:0] p
);
   import bps_pkg::*;

   logic signed [PROD_W-1:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end

   assign p = p_ff;

endmodule

// File: src/bps_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module bps_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bps_pkg::SQ_W-1:0]    radicand,
   output logic                         done,
   output logic [bps_pkg::ROOT_W-1:0]  root
);
   import bps_pkg::*;

   logic            busy_ff;
   logic            done_ff;
   logic [SQ_W-1:0] rem_ff;
   logic [SQ_W-1:0] res_ff;
   logic [SQ_W-1:0] bit_ff;
   logic [SQ_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            rem_ff  <= radicand;
            res_ff  <= '0;
            bit_ff  <= SQ_W'(1) << (SQ_W - 2);
         end else if (busy_ff) begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff == SQ_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

// File: src/bps_div.sv
// Restoring divider, one quotient bit per cycle, quotient known to fit QUO_W bits.
module bps_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bps_pkg::DIV_W-1:0]   dividend,
   input  logic [bps_pkg::ROOT_W-1:0]  divisor,
   output logic                         done,
   output logic [bps_pkg::QUO_W-1:0]   quotient
);
   import bps_pkg::*;

   logic                     busy_ff;
   logic                     done_ff;
   logic [DIV_W-1:0]         rem_ff;
   logic [DIV_W-1:0]         dsr_ff;
   logic [QUO_W-1:0]         quo_ff;
   logic [$clog2(QUO_W)-1:0] step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            rem_ff  <= dividend;
            dsr_ff  <= DIV_W'(divisor) << (QUO_W - 1);
            quo_ff  <= '0;
            step_ff <= ($clog2(QUO_W))'(QUO_W - 1);
         end else if (busy_ff) begin
            if (rem_ff >= dsr_ff) begin
               rem_ff <= rem_ff - dsr_ff;
               quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
            end
            dsr_ff <= dsr_ff >> 1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: src/blinn_phong_fragment_shade_unit.sv
// Top level of the Blinn-Phong fragment shading unit: sequencer, stores and register port.
//
// Usage. Items enter on the req_ channel (valid/ready). A load item (mode 0)
// writes one triangle vertex into slot 0, 1 or 2; slot 3 is ignored. A shade
// item (mode 1) interpolates position and normal from the three stored
// vertices, normalizes the normal, light, view and half vectors, and yields
// one RGB result with a clipped flag on the rsp_ channel. Light and eye
// positions are to be written by the user through the csr_ port only while
// idle; the block itself does not enforce this. The time of a shade item
// varies with the normalizing shifts, and a vector that is all zero skips
// its normalization. Most of the time goes to the one-bit-per-cycle square
// root (32 steps) and the three 15-step divides of each of the four
// normalizations. All products go through one shared multiplier. One shade
// item is in flight at a time. The finished result sits in an output
// register, so the next item is accepted while a stalled receiver has not
// yet taken it; a following result waits in its last step until that
// register is free. Reset clears the sequencer, the result valid flag and
// the light and eye registers; vertex slots read as undefined until loaded.
module blinn_phong_fragment_shade_unit #(
   parameter int SPEC_EXPONENT = 150
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bps_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bps_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [4:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   import bps_pkg::*;

   localparam int EXP_BITS = $clog2(SPEC_EXPONENT + 1);
   localparam logic [EXP_BITS-1:0] EXP_VEC = EXP_BITS'(SPEC_EXPONENT);
   localparam int VW = 53;   // working vector width
   localparam int FW = 52;   // interpolated position width
   localparam int NW = 35;   // interpolated normal width
   localparam logic [MUL_W-1:0] DIF_Q16 = MUL_W'(58982);
   localparam logic [MUL_W-1:0] SPC_Q16 = MUL_W'(1989609);
   localparam logic [32:0]      AMB_TERM = 33'(22938 * 65536);
   localparam logic [16:0]      ONE_Q16 = 17'(65536);

   typedef enum logic [4:0] {
      S_IDLE, S_INTERP, S_IDRAIN, S_LOADV, S_ABS, S_MAX, S_SHIFT, S_SQ, S_SQWAIT,
      S_SQRT_GO, S_SQRT_WAIT, S_DIV_GO, S_DIV_WAIT, S_DOT, S_DOTWAIT, S_DOTFIN,
      S_POW_R, S_POW_B, S_POW_W, S_COL_A, S_COL_B, S_COL_C, S_COL_W, S_DONE
   } state_type;

   typedef enum logic [3:0] {
      D_NONE, D_FRAG, D_NRM, D_SQ, D_DOT, D_RES, D_BASE, D_XC, D_SP, D_CH
   } dest_type;

   typedef enum logic [1:0] {T_NRM, T_LGT, T_VEW, T_HLF} target_type;

   state_type   state_ff;
   target_type  tgt_ff;
   dest_type    dest_ff, iss_dest;
   logic [1:0]  didx_ff, iss_idx;
   logic [4:0]  cnt_ff;
   logic [1:0]  idx_ff;
   logic        sel_ff;

   logic signed [31:0] light_ff [VERT_COUNT];
   logic signed [31:0] eye_ff   [VERT_COUNT];
   logic signed [31:0] vp_ff    [VERT_COUNT][VERT_COUNT];
   logic signed [15:0] vn_ff    [VERT_COUNT][VERT_COUNT];
   logic        [16:0] w_ff     [VERT_COUNT];
   logic        [23:0] texel_ff;

   logic signed [FW-1:0] frag_ff [VERT_COUNT];
   logic signed [NW-1:0] nv_ff   [VERT_COUNT];
   logic signed [VW-1:0] vec_ff  [VERT_COUNT];
   logic        [VW-1:0] a_ff    [VERT_COUNT];
   logic                 neg_ff  [VERT_COUNT];
   logic        [VW-1:0] m_ff;
   logic        [SQ_W-1:0] s_ff;
   logic signed [15:0] nu_ff [VERT_COUNT];
   logic signed [15:0] lu_ff [VERT_COUNT];
   logic signed [15:0] vu_ff [VERT_COUNT];
   logic signed [15:0] hu_ff [VERT_COUNT];
   logic signed [31:0] dot_ff;
   logic        [16:0] diff_ff, res_ff, base_ff;
   logic [EXP_BITS-1:0] exp_ff;
   logic        [32:0] xcol_ff;
   logic        [37:0] sp_ff;
   logic        [7:0]  ch_ff [VERT_COUNT];
   logic               clip_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_data_ff;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   logic                     sqrt_start, sqrt_done, div_start, div_done;
   logic [ROOT_W-1:0]        root;
   logic [QUO_W-1:0]         quo;
   logic [DIV_W-1:0]         dividend;
   logic [3:0]               vij;
   logic [VW-1:0]            max_a;
   logic [16:0]              dot_q;
   logic signed [15:0]       uval;
   logic [41:0]              acc;
   logic [9:0]               chv;
   logic [33:0]              rnd;
   logic                     cfg_write;
   logic [7:0]               chan;

   // Vertex and component of one interpolation product pair.
   function automatic logic [3:0] split_pair(input logic [3:0] p);
      logic [3:0] r;
      case (p)
         4'd0: r = {2'd0, 2'd0};
         4'd1: r = {2'd0, 2'd1};
         4'd2: r = {2'd0, 2'd2};
         4'd3: r = {2'd1, 2'd0};
         4'd4: r = {2'd1, 2'd1};
         4'd5: r = {2'd1, 2'd2};
         4'd6: r = {2'd2, 2'd0};
         4'd7: r = {2'd2, 2'd1};
         4'd8: r = {2'd2, 2'd2};
         default: r = {2'd0, 2'd0};
      endcase
      return r;
   endfunction

   function automatic target_type next_tgt(input target_type t);
      target_type r;
      case (t)
         T_NRM:   r = T_LGT;
         T_LGT:   r = T_VEW;
         default: r = T_HLF;
      endcase
      return r;
   endfunction

   bps_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p(prod));

   bps_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .radicand(s_ff),
      .done(sqrt_done), .root(root)
   );

   bps_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dividend),
      .divisor(root), .done(div_done), .quotient(quo)
   );

   assign vij = split_pair(cnt_ff[4:1]);
   assign sqrt_start = (state_ff == S_SQRT_GO);
   assign div_start  = (state_ff == S_DIV_GO);
   assign dividend = {2'b0, a_ff[idx_ff][29:0], 14'b0} + {15'b0, root[ROOT_W-1:1]};
   assign uval = neg_ff[idx_ff] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

   always_comb begin
      max_a = a_ff[0];
      if (a_ff[1] > max_a) begin
         max_a = a_ff[1];
      end
      if (a_ff[2] > max_a) begin
         max_a = a_ff[2];
      end
   end

   // Dot product in Q.28 to Q1.16, with negative results cut to zero and results above one clamped to one.
   always_comb begin
      logic [31:0] t;
      t = 32'(dot_ff) + 32'd2048;
      if (dot_ff <= 0) begin
         dot_q = '0;
      end else if (t[31:12] > 20'(ONE_Q16)) begin
         dot_q = ONE_Q16;
      end else begin
         dot_q = t[28:12];
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    chan = texel_ff[23:16];
         2'd1:    chan = texel_ff[15:8];
         default: chan = texel_ff[7:0];
      endcase
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      iss_dest = D_NONE;
      iss_idx  = idx_ff;
      case (state_ff)
         S_INTERP: begin
            mul_a   = {17'b0, w_ff[vij[3:2]]};
            iss_idx = vij[1:0];
            if (cnt_ff[0]) begin
               mul_b    = MUL_W'(vn_ff[vij[3:2]][vij[1:0]]);
               iss_dest = D_NRM;
            end else begin
               mul_b    = MUL_W'(vp_ff[vij[3:2]][vij[1:0]]);
               iss_dest = D_FRAG;
            end
         end
         S_SQ: begin
            mul_a    = {4'b0, a_ff[idx_ff][29:0]};
            mul_b    = {4'b0, a_ff[idx_ff][29:0]};
            iss_dest = D_SQ;
         end
         S_DOT: begin
            mul_a    = sel_ff ? MUL_W'(hu_ff[idx_ff]) : MUL_W'(lu_ff[idx_ff]);
            mul_b    = MUL_W'(nu_ff[idx_ff]);
            iss_dest = D_DOT;
         end
         S_POW_R: begin
            if (exp_ff[0]) begin
               mul_a    = {17'b0, res_ff};
               mul_b    = {17'b0, base_ff};
               iss_dest = D_RES;
            end
         end
         S_POW_B: begin
            mul_a    = {17'b0, base_ff};
            mul_b    = {17'b0, base_ff};
            iss_dest = D_BASE;
         end
         S_COL_A: begin
            mul_a    = DIF_Q16;
            mul_b    = {17'b0, diff_ff};
            iss_dest = D_XC;
         end
         S_COL_B: begin
            mul_a    = SPC_Q16;
            mul_b    = {17'b0, res_ff};
            iss_dest = D_SP;
         end
         S_COL_C: begin
            mul_a    = {26'b0, chan};
            mul_b    = {1'b0, xcol_ff};
            iss_dest = D_CH;
         end
         default: begin
            iss_dest = D_NONE;
         end
      endcase
   end

   assign rnd = prod[33:0] + 34'd32768;
   assign acc = {1'b0, prod[40:0]} + {4'b0, sp_ff} + 42'h0_8000_0000;
   assign chv = acc[41:32];

   assign cfg_write = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dest_ff      <= D_NONE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < VERT_COUNT; i++) begin
            light_ff[i] <= '0;
            eye_ff[i]   <= '0;
         end
      end else begin
         dest_ff <= iss_dest;
         didx_ff <= iss_idx;

         if (cfg_write) begin
            case (csr_reg_type'(csr_paddr[4:2]))
               REG_LIGHT_X: light_ff[0] <= csr_pwdata;
               REG_LIGHT_Y: light_ff[1] <= csr_pwdata;
               REG_LIGHT_Z: light_ff[2] <= csr_pwdata;
               REG_EYE_X:   eye_ff[0]   <= csr_pwdata;
               REG_EYE_Y:   eye_ff[1]   <= csr_pwdata;
               REG_EYE_Z:   eye_ff[2]   <= csr_pwdata;
               default: ;
            endcase
         end

         // In the last step a taken result is replaced by the next one below.
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_data.mode == MODE_LOAD) begin
                     if (req_data.vertex_slot != 2'd3) begin
                        vp_ff[req_data.vertex_slot][0] <= req_data.world_x;
                        vp_ff[req_data.vertex_slot][1] <= req_data.world_y;
                        vp_ff[req_data.vertex_slot][2] <= req_data.world_z;
                        vn_ff[req_data.vertex_slot][0] <= req_data.norm_x;
                        vn_ff[req_data.vertex_slot][1] <= req_data.norm_y;
                        vn_ff[req_data.vertex_slot][2] <= req_data.norm_z;
                     end
                  end else begin
                     w_ff[0]  <= req_data.weight_first;
                     w_ff[1]  <= req_data.weight_second;
                     w_ff[2]  <= req_data.weight_third;
                     texel_ff <= req_data.texel_rgb;
                     for (int i = 0; i < VERT_COUNT; i++) begin
                        frag_ff[i] <= '0;
                        nv_ff[i]   <= '0;
                     end
                     clip_ff  <= 1'b0;
                     cnt_ff   <= '0;
                     state_ff <= S_INTERP;
                  end
               end
            end
            S_INTERP: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd17) begin
                  state_ff <= S_IDRAIN;
               end
            end
            S_IDRAIN: begin
               tgt_ff   <= T_NRM;
               state_ff <= S_LOADV;
            end
            S_LOADV: begin
               for (int i = 0; i < VERT_COUNT; i++) begin
                  case (tgt_ff)
                     T_NRM:   vec_ff[i] <= VW'(nv_ff[i]);
                     T_LGT:   vec_ff[i] <= {{5{light_ff[i][31]}}, light_ff[i], 16'b0}
                                           - VW'(frag_ff[i]);
                     T_VEW:   vec_ff[i] <= {{5{eye_ff[i][31]}}, eye_ff[i], 16'b0}
                                           - VW'(frag_ff[i]);
                     default: vec_ff[i] <= VW'(lu_ff[i]) + VW'(vu_ff[i]);
                  endcase
               end
               state_ff <= S_ABS;
            end
            S_ABS: begin
               for (int i = 0; i < VERT_COUNT; i++) begin
                  neg_ff[i] <= vec_ff[i][VW-1];
                  a_ff[i]   <= vec_ff[i][VW-1] ? VW'(-vec_ff[i]) : VW'(vec_ff[i]);
               end
               state_ff <= S_MAX;
            end
            S_MAX: begin
               m_ff <= max_a;
               s_ff <= '0;
               if (max_a == '0) begin
                  // A zero vector stays zero and adds no light.
                  for (int i = 0; i < VERT_COUNT; i++) begin
                     case (tgt_ff)
                        T_NRM:   nu_ff[i] <= '0;
                        T_LGT:   lu_ff[i] <= '0;
                        T_VEW:   vu_ff[i] <= '0;
                        default: hu_ff[i] <= '0;
                     endcase
                  end
                  if (tgt_ff == T_HLF) begin
                     idx_ff   <= '0;
                     sel_ff   <= 1'b0;
                     dot_ff   <= '0;
                     state_ff <= S_DOT;
                  end else begin
                     tgt_ff   <= next_tgt(tgt_ff);
                     state_ff <= S_LOADV;
                  end
               end else begin
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               // Bring the largest magnitude into [2^29, 2^30).
               if (m_ff[VW-1:30] != '0) begin
                  for (int i = 0; i < VERT_COUNT; i++) begin
                     a_ff[i] <= a_ff[i] >> 1;
                  end
                  m_ff <= m_ff >> 1;
               end else if (m_ff[VW-1:29] == '0) begin
                  for (int i = 0; i < VERT_COUNT; i++) begin
                     a_ff[i] <= a_ff[i] << 1;
                  end
                  m_ff <= m_ff << 1;
               end else begin
                  idx_ff   <= '0;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               if (idx_ff == 2'd2) begin
                  idx_ff   <= '0;
                  state_ff <= S_SQWAIT;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_SQWAIT: begin
               state_ff <= S_SQRT_GO;
            end
            S_SQRT_GO: begin
               state_ff <= S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
               if (sqrt_done) begin
                  idx_ff   <= '0;
                  state_ff <= S_DIV_GO;
               end
            end
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  case (tgt_ff)
                     T_NRM:   nu_ff[idx_ff] <= uval;
                     T_LGT:   lu_ff[idx_ff] <= uval;
                     T_VEW:   vu_ff[idx_ff] <= uval;
                     default: hu_ff[idx_ff] <= uval;
                  endcase
                  if (idx_ff != 2'd2) begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_DIV_GO;
                  end else if (tgt_ff == T_HLF) begin
                     idx_ff   <= '0;
                     sel_ff   <= 1'b0;
                     dot_ff   <= '0;
                     state_ff <= S_DOT;
                  end else begin
                     tgt_ff   <= next_tgt(tgt_ff);
                     state_ff <= S_LOADV;
                  end
               end
            end
            S_DOT: begin
               if (idx_ff == 2'd2) begin
                  idx_ff   <= '0;
                  state_ff <= S_DOTWAIT;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_DOTWAIT: begin
               state_ff <= S_DOTFIN;
            end
            S_DOTFIN: begin
               dot_ff <= '0;
               if (!sel_ff) begin
                  diff_ff  <= dot_q;
                  sel_ff   <= 1'b1;
                  state_ff <= S_DOT;
               end else begin
                  base_ff  <= dot_q;
                  res_ff   <= ONE_Q16;
                  exp_ff   <= EXP_VEC;
                  state_ff <= S_POW_R;
               end
            end
            S_POW_R: begin
               state_ff <= S_POW_B;
            end
            S_POW_B: begin
               state_ff <= S_POW_W;
            end
            S_POW_W: begin
               exp_ff <= exp_ff >> 1;
               if ((exp_ff >> 1) == '0) begin
                  state_ff <= S_COL_A;
               end else begin
                  state_ff <= S_POW_R;
               end
            end
            S_COL_A: begin
               state_ff <= S_COL_B;
            end
            S_COL_B: begin
               idx_ff   <= '0;
               state_ff <= S_COL_C;
            end
            S_COL_C: begin
               if (idx_ff == 2'd2) begin
                  state_ff <= S_COL_W;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_COL_W: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff.red     <= ch_ff[0];
                  rsp_data_ff.green   <= ch_ff[1];
                  rsp_data_ff.blue    <= ch_ff[2];
                  rsp_data_ff.clipped <= clip_ff;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // Products come back in the cycle after issue.
         case (dest_ff)
            D_FRAG: frag_ff[didx_ff] <= frag_ff[didx_ff] + prod[FW-1:0];
            D_NRM:  nv_ff[didx_ff]   <= nv_ff[didx_ff] + prod[NW-1:0];
            D_SQ:   s_ff   <= s_ff + prod[SQ_W-1:0];
            D_DOT:  dot_ff <= dot_ff + prod[31:0];
            D_RES:  res_ff  <= rnd[32:16];
            D_BASE: base_ff <= rnd[32:16];
            D_XC:   xcol_ff <= AMB_TERM + prod[32:0];
            D_SP:   sp_ff   <= prod[37:0];
            D_CH: begin
               if (chv > 10'd255) begin
                  ch_ff[didx_ff] <= 8'd255;
                  clip_ff        <= 1'b1;
               end else begin
                  ch_ff[didx_ff] <= chv[7:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg_type'(csr_paddr[4:2]))
         REG_LIGHT_X: csr_prdata = light_ff[0];
         REG_LIGHT_Y: csr_prdata = light_ff[1];
         REG_LIGHT_Z: csr_prdata = light_ff[2];
         REG_EYE_X:   csr_prdata = eye_ff[0];
         REG_EYE_Y:   csr_prdata = eye_ff[1];
         REG_EYE_Z:   csr_prdata = eye_ff[2];
         default:     csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// File: src/bps_chk.sv
// Port-level checks of the shading unit and their binding to the top level.
module bps_chk (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input bps_pkg::req_payload_type req_data,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input bps_pkg::rsp_payload_type rsp_data
);
   import bps_pkg::*;

   // A result held back by the receiver keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The clipped flag is only set when some channel sits at full scale.
   a_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.red != 8'd255 && rsp_data.green != 8'd255 &&
      rsp_data.blue != 8'd255 |-> !rsp_data.clipped)
      else $error("clipped without a saturated channel");

   // A shade item occupies the sequencer.
   a_shade_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.mode == MODE_SHADE |=> !req_ready)
      else $error("ready right after a shade item");

   // A vertex load leaves the sequencer idle and ready.
   a_load_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.mode == MODE_LOAD |=> req_ready)
      else $error("not ready after a load item");

endmodule

bind blinn_phong_fragment_shade_unit bps_chk u_bps_chk (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data(req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);
